// File: src/stws_pkg.sv
package stws_pkg;

    localparam int NUM_SEMS    = 32;
    localparam int NUM_TASKS   = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int SEM_W       = $clog2(NUM_SEMS);
    localparam int TASK_W      = $clog2(NUM_TASKS);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef logic [1:0] t_act;
    localparam t_act ACT_OPEN  = 2'd0;
    localparam t_act ACT_CLOSE = 2'd1;
    localparam t_act ACT_WAIT  = 2'd2;
    localparam t_act ACT_POST  = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_BLOCKED = 2'd1;
    localparam t_status ST_INVALID = 2'd2;

    // One wait-stack link: valid flag plus task id.
    typedef struct packed {
        logic              vld;
        logic [TASK_W-1:0] tid;
    } t_link;

    // One semaphore table entry.
    typedef struct packed {
        logic                   active;
        logic                   binary;
        logic [COUNT_WIDTH-1:0] count;
        t_link                  head;
    } t_sem_ent;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;     // latch request, read semaphore entry
        logic link_rd;  // read link of the stack top
        logic exec;     // update entry, write link, load result
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free; // result register can take a new transaction
    } t_sts;

endpackage

// File: src/stws_dp.sv
module stws_dp
    import stws_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  t_act                   i_action,
    input  logic [SEM_W-1:0]       i_sem_index,
    input  logic [TASK_W-1:0]      i_current_task,
    input  logic                   i_open_binary,
    input  logic [COUNT_WIDTH-1:0] i_init_value,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output t_status                o_status,
    output logic [COUNT_WIDTH-1:0] o_old_count,
    output logic                   o_woken_valid,
    output logic [TASK_W-1:0]      o_woken_task
);

    // Request registers
    t_act                   r_act;
    logic [SEM_W-1:0]       r_sem;
    logic [TASK_W-1:0]      r_task;
    logic                   r_bin;
    logic [COUNT_WIDTH-1:0] r_init;

    // Storage
    t_sem_ent               r_sem_mem [NUM_SEMS];
    logic [NUM_SEMS-1:0]    r_sem_vld;
    t_link                  r_link_mem [NUM_TASKS];

    // Registered read data
    t_sem_ent               r_sem_q;
    logic                   r_sem_q_vld;
    t_link                  r_link_q;

    // Result register
    logic                   r_out_vld;
    t_status                r_status;
    logic [COUNT_WIDTH-1:0] r_old;
    logic                   r_wv;
    logic [TASK_W-1:0]      r_wt;

    t_sem_ent               ent;
    t_sem_ent               n_ent;
    logic                   link_we;
    t_status                n_status;
    logic [COUNT_WIDTH-1:0] n_old;
    logic                   n_wv;
    logic [TASK_W-1:0]      n_wt;

    // Never-written entries read as the reset value.
    assign ent = r_sem_q_vld ? r_sem_q : '0;

    always_comb begin
        n_ent    = ent;
        link_we  = 1'b0;
        n_status = ST_DONE;
        n_old    = '0;
        n_wv     = 1'b0;
        n_wt     = '0;
        unique case (r_act)
            ACT_OPEN: begin
                n_ent.active = 1'b1;
                n_ent.binary = r_bin;
                n_ent.count  = r_bin ? COUNT_WIDTH'(r_init != '0) : r_init;
            end
            ACT_CLOSE: begin
                n_ent.active = 1'b0;
            end
            ACT_WAIT: begin
                if (!ent.active) begin
                    n_status = ST_INVALID;
                end else if (ent.count == '0) begin
                    // push the requester onto the wait stack
                    n_status       = ST_BLOCKED;
                    link_we        = 1'b1;
                    n_ent.head.vld = 1'b1;
                    n_ent.head.tid = r_task;
                end else begin
                    n_old       = ent.count;
                    n_ent.count = ent.binary ? '0 : ent.count - 1'b1;
                end
            end
            ACT_POST: begin
                if (!ent.active) begin
                    n_status = ST_INVALID;
                end else if (ent.head.vld) begin
                    // pop the most recent waiter
                    n_wv       = 1'b1;
                    n_wt       = ent.head.tid;
                    n_ent.head = r_link_q;
                end else if (ent.binary) begin
                    n_ent.count = COUNT_WIDTH'(1'b1);
                end else if (ent.count != COUNT_MAX) begin
                    n_ent.count = ent.count + 1'b1;
                end
            end
            default: begin
                n_ent = ent;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act       <= i_action;
            r_sem       <= i_sem_index;
            r_task      <= i_current_task;
            r_bin       <= i_open_binary;
            r_init      <= i_init_value;
            r_sem_q     <= r_sem_mem[i_sem_index];
            r_sem_q_vld <= r_sem_vld[i_sem_index];
        end
        if (i_cmd.exec) begin
            r_sem_mem[r_sem] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link_rd) begin
            r_link_q <= r_link_mem[ent.head.tid];
        end
        if (i_cmd.exec && link_we) begin
            r_link_mem[r_task] <= ent.head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sem_vld <= '0;
        end else if (i_cmd.exec) begin
            r_sem_vld[r_sem] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_old    <= n_old;
            r_wv     <= n_wv;
            r_wt     <= n_wt;
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_status       = r_status;
    assign o_old_count    = r_old;
    assign o_woken_valid  = r_wv;
    assign o_woken_task   = r_wt;

endmodule

// File: src/stws_ctrl.sv
module stws_ctrl
    import stws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LINK = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load    = o_in_ready && i_in_valid;
    assign o_cmd.link_rd = (r_state == S_LINK);
    assign o_cmd.exec    = (r_state == S_EXEC) && i_sts.out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // hold until the result register frees up
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/semaphore_table_with_wait_stacks_top.sv
// Hardware semaphore table: 32 semaphores, each binary or counting with a
// 16-bit count, and each with a LIFO stack of waiting tasks (task ids 0..63).
// One request transaction on the slave stream gives exactly one result
// transaction on the master stream. Open activates a semaphore, sets its mode
// and loads its count (binary keeps any nonzero value as 1); close deactivates
// it. Neither touches the wait stack. Wait takes a unit and reports the old
// count, or pushes the task and reports blocked. Post wakes the most recent
// waiter, or raises the count (binary sets 1, counting saturates). Wait and
// post on an inactive semaphore report status 2. Requests are handled one at
// a time: each goes through a semaphore table read, a wait-stack link read,
// then the update, and a new request is taken only once the last one's update
// is done; a stalled result holds the update step until the output register
// frees. The table starts cleared at reset with no clearing pass.
module semaphore_table_with_wait_stacks_top
    import stws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [1:0] action, [6:2] sem_index, [12:7] current_task, [13] open_binary,
    // [29:14] init_value, [31:30] zero
    input  logic [31:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [1:0] status, [17:2] old_count, [18] woken_valid, [24:19] woken_task,
    // [31:25] zero
    output logic [31:0] o_m_tdata
);

    t_cmd                   cmd;
    t_sts                   sts;
    t_status                status;
    logic [COUNT_WIDTH-1:0] old_count;
    logic                   woken_valid;
    logic [TASK_W-1:0]      woken_task;

    // Sequence each request transaction through read, link and update steps.
    stws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Semaphore table, wait-stack links and the result register.
    stws_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_s_tdata[1:0]),
        .i_sem_index    (i_s_tdata[6:2]),
        .i_current_task (i_s_tdata[12:7]),
        .i_open_binary  (i_s_tdata[13]),
        .i_init_value   (i_s_tdata[29:14]),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_status       (status),
        .o_old_count    (old_count),
        .o_woken_valid  (woken_valid),
        .o_woken_task   (woken_task)
    );

    // Pack the result transaction, lowest field first.
    assign o_m_tdata = {7'd0, woken_task, woken_valid, old_count, status};

endmodule

// File: dv/tb_semaphore_table_with_wait_stacks_top.sv
module tb_semaphore_table_with_wait_stacks_top;
    import stws_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 7;
    localparam int RAND_REQS    = 1200;
    localparam int IDLE_PCT     = 34;
    localparam int HOLDOFF_AT   = 300;   // requests accepted before the long result stall
    localparam int HOLDOFF_LEN  = 400;   // cycles of the long result stall
    localparam int QUIET_FROM   = 700;   // accepted-request window with no idling at all
    localparam int QUIET_TO     = 950;
    localparam int DRAIN_AT     = 600;   // random request that waits for an empty pipe
    localparam int TAIL_CYCLES  = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 40;

    // One request transaction on the slave stream.
    typedef struct {
        t_act                   act;
        logic [SEM_W-1:0]       sem;
        logic [TASK_W-1:0]      tid;
        logic                   bin;
        logic [COUNT_WIDTH-1:0] init;
        bit                     drain_first;   // hold the offer until nothing is pending
    } sem_req_t;

    // One result transaction on the master stream.
    typedef struct {
        t_status                status;
        logic [COUNT_WIDTH-1:0] old_count;
        logic                   woken_vld;
        logic [TASK_W-1:0]      woken_tid;
    } sem_res_t;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // [1:0] action, [6:2] sem_index, [12:7] current_task, [13] open_binary,
    // [29:14] init_value, [31:30] zero
    logic [31:0] i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // [1:0] status, [17:2] old_count, [18] woken_valid, [24:19] woken_task,
    // [31:25] zero
    logic [31:0] o_m_tdata;

    semaphore_table_with_wait_stacks_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shadow copy of the semaphore table and the wait-stack links.
    logic                   sem_on    [NUM_SEMS];
    logic                   sem_bin   [NUM_SEMS];
    logic [COUNT_WIDTH-1:0] sem_cnt   [NUM_SEMS];
    t_link                  sem_top   [NUM_SEMS];
    t_link                  next_waiter[NUM_TASKS];

    sem_req_t pending_reqs[$];
    sem_res_t expected_results[$];

    int  cycle_cnt    = 0;
    int  accepted_cnt = 0;
    int  result_cnt   = 0;
    int  error_cnt    = 0;
    int  n_acquired   = 0;
    int  n_blocked    = 0;
    int  n_woken      = 0;
    int  n_invalid    = 0;
    int  stall_left   = 0;
    bit  stall_done   = 0;
    bit  req_taken    = 0;   // slave transaction completed at the last rising edge
    bit  quiet;

    assign quiet = accepted_cnt >= QUIET_FROM && accepted_cnt < QUIET_TO;

    // Apply one request to the shadow table and return the result it yields.
    function automatic sem_res_t apply_request(sem_req_t r);
        sem_res_t res;
        res.status    = ST_DONE;
        res.old_count = '0;
        res.woken_vld = 1'b0;
        res.woken_tid = '0;
        case (r.act)
            ACT_OPEN: begin
                sem_on[r.sem]  = 1'b1;
                sem_bin[r.sem] = r.bin;
                sem_cnt[r.sem] = r.bin ? COUNT_WIDTH'(r.init != '0) : r.init;
            end
            ACT_CLOSE: sem_on[r.sem] = 1'b0;
            default: begin
                if (!sem_on[r.sem]) begin
                    res.status = ST_INVALID;
                end else if (r.act == ACT_WAIT) begin
                    if (sem_cnt[r.sem] == '0) begin
                        // push the requester; its link keeps the former top
                        res.status       = ST_BLOCKED;
                        next_waiter[r.tid] = sem_top[r.sem];
                        sem_top[r.sem].vld = 1'b1;
                        sem_top[r.sem].tid = r.tid;
                    end else begin
                        res.old_count  = sem_cnt[r.sem];
                        sem_cnt[r.sem] = sem_bin[r.sem] ? '0 : sem_cnt[r.sem] - 1'b1;
                    end
                end else begin
                    if (sem_top[r.sem].vld) begin
                        res.woken_vld  = 1'b1;
                        res.woken_tid  = sem_top[r.sem].tid;
                        sem_top[r.sem] = next_waiter[sem_top[r.sem].tid];
                    end else if (sem_bin[r.sem]) begin
                        sem_cnt[r.sem] = COUNT_WIDTH'(1);
                    end else if (sem_cnt[r.sem] != COUNT_MAX) begin
                        sem_cnt[r.sem] = sem_cnt[r.sem] + 1'b1;
                    end
                end
            end
        endcase
        return res;
    endfunction

    task automatic queue_req(t_act act, int sem, int tid, bit bin, int init, bit drain = 0);
        sem_req_t r;
        r.act         = act;
        r.sem         = SEM_W'(sem);
        r.tid         = TASK_W'(tid);
        r.bin         = bin;
        r.init        = COUNT_WIDTH'(init);
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    // Rising edge: complete slave transactions into the predictor, compare
    // master transactions against the oldest expectation, watch the limit.
    always @(posedge i_clk) begin
        sem_res_t exp_r;
        sem_res_t got;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $realtime, cycle_cnt, expected_results.size());
            $display("** semaphore_table_with_wait_stacks_top: FAILED **");
            $finish;
        end
        req_taken = 0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status    = o_m_tdata[1:0];
                got.old_count = o_m_tdata[17:2];
                got.woken_vld = o_m_tdata[18];
                got.woken_tid = o_m_tdata[24:19];
                result_cnt++;
                if (expected_results.size() == 0) begin
                    error_cnt++;
                    if (error_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected result 0x%08h, nothing pending",
                                 $realtime, o_m_tdata);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.status !== exp_r.status || got.old_count !== exp_r.old_count ||
                        got.woken_vld !== exp_r.woken_vld ||
                        got.woken_tid !== exp_r.woken_tid) begin
                        error_cnt++;
                        if (error_cnt <= MAX_REPORTS) begin
                            $display("%0t: result mismatch: expected status %0d old %0d woken %0b/%0d",
                                     $realtime, exp_r.status, exp_r.old_count,
                                     exp_r.woken_vld, exp_r.woken_tid);
                            $display("%0t:                  got status %0d old %0d woken %0b/%0d",
                                     $realtime, got.status, got.old_count,
                                     got.woken_vld, got.woken_tid);
                        end
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                sem_req_t r;
                r.act  = i_s_tdata[1:0];
                r.sem  = i_s_tdata[6:2];
                r.tid  = i_s_tdata[12:7];
                r.bin  = i_s_tdata[13];
                r.init = i_s_tdata[29:14];
                exp_r  = apply_request(r);
                case (exp_r.status)
                    ST_BLOCKED: n_blocked++;
                    ST_INVALID: n_invalid++;
                    default: begin
                        if (r.act == ACT_WAIT) n_acquired++;
                        if (exp_r.woken_vld)   n_woken++;
                    end
                endcase
                expected_results.push_back(exp_r);
                accepted_cnt++;
                req_taken = 1;
            end
        end
    end

    // Request driver: hold an offer until it is taken, then advance or idle.
    always @(negedge i_clk) begin
        sem_req_t r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || req_taken) begin
            if (pending_reqs.size() > 0 &&
                (!pending_reqs[0].drain_first || expected_results.size() == 0) &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                r = pending_reqs.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {2'b00, r.init, r.bin, r.tid, r.sem, r.act};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: random back-pressure plus one long stall so the block
    // fills up and drops o_s_tready while requests keep coming.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!stall_done && accepted_cnt >= HOLDOFF_AT) begin
            stall_done = 1;
            stall_left = HOLDOFF_LEN - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= quiet || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    initial begin
        int pick;
        int sem;
        int init;
        t_act act;

        for (int s = 0; s < NUM_SEMS; s++) begin
            sem_on[s]  = 1'b0;
            sem_bin[s] = 1'b0;
            sem_cnt[s] = '0;
            sem_top[s] = '0;
        end

        // Directed: requests on closed semaphores, count extremes, binary
        // clamping, LIFO wake order, stack kept across close and reopen, and
        // one task pushed twice on the same stack.
        queue_req(ACT_WAIT,  0,  0, 0, 0);
        queue_req(ACT_POST,  31, 63, 1, 16'hFFFF);
        queue_req(ACT_CLOSE, 5,  1, 0, 0);
        queue_req(ACT_OPEN,  31, 0, 0, 16'hFFFF);
        queue_req(ACT_POST,  31, 0, 0, 0);          // count saturates
        queue_req(ACT_WAIT,  31, 7, 0, 0);          // old count is all ones
        queue_req(ACT_OPEN,  0,  0, 1, 16'hABCD);   // binary keeps nonzero as one
        queue_req(ACT_WAIT,  0,  63, 0, 0);
        queue_req(ACT_WAIT,  0,  5, 0, 0);          // blocks
        queue_req(ACT_WAIT,  0,  42, 0, 0);         // blocks on top of task 5
        queue_req(ACT_POST,  0,  0, 0, 0);          // wakes 42
        queue_req(ACT_CLOSE, 0,  0, 0, 0);
        queue_req(ACT_POST,  0,  0, 0, 0);          // closed: invalid
        queue_req(ACT_OPEN,  0,  0, 1, 0);          // reopen, stack still holds 5
        queue_req(ACT_POST,  0,  0, 0, 0);          // wakes 5
        queue_req(ACT_POST,  0,  0, 0, 0);          // binary count set to one
        queue_req(ACT_POST,  0,  0, 0, 0);          // stays at one
        queue_req(ACT_OPEN,  30, 0, 0, 0);          // counting, empty
        queue_req(ACT_WAIT,  30, 9, 0, 16'h5555);
        queue_req(ACT_WAIT,  30, 9, 1, 16'hAAAA);   // same task pushed again
        queue_req(ACT_POST,  30, 0, 0, 0);
        queue_req(ACT_POST,  30, 0, 0, 0);
        queue_req(ACT_OPEN,  17, 0, 0, 1);
        queue_req(ACT_POST,  17, 0, 0, 0);
        queue_req(ACT_WAIT,  17, 0, 0, 0);          // old count two

        // Random: most traffic on a few semaphores so stacks grow and drain,
        // the rest spread over the whole table with full-range fields.
        for (int i = 0; i < RAND_REQS; i++) begin
            sem  = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4)
                                                : $urandom_range(0, NUM_SEMS - 1);
            pick = $urandom_range(0, 99);
            if (pick < 12)      act = ACT_OPEN;
            else if (pick < 16) act = ACT_CLOSE;
            else if (pick < 58) act = ACT_WAIT;
            else                act = ACT_POST;
            pick = $urandom_range(0, 99);
            if (pick < 60)      init = $urandom_range(0, 3);
            else if (pick < 85) init = $urandom_range(0, 16'hFFFF);
            else                init = (pick < 90) ? 16'hFFFF : (pick < 95) ? 16'hFFFE : 0;
            queue_req(act, sem, $urandom_range(0, NUM_TASKS - 1), $urandom_range(0, 1),
                      init, i == DRAIN_AT);
        end

        // Hold reset, then release at a falling edge.
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent, every result back, then a short tail.
        while (!(pending_reqs.size() == 0 && !i_s_tvalid && expected_results.size() == 0))
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        error_cnt += expected_results.size();

        $display("Ran %0d requests, %0d results: %0d acquired, %0d blocked, %0d woken,",
                 accepted_cnt, result_cnt, n_acquired, n_blocked, n_woken);
        $display("%0d on closed semaphores, with result stalls and one drained pause.",
                 n_invalid);
        if (error_cnt == 0) begin
            $display("** semaphore_table_with_wait_stacks_top: PASSED **");
        end else begin
            $display("** semaphore_table_with_wait_stacks_top: FAILED **");
        end
        $finish;
    end

endmodule
